// File: design/ecal_pkg.sv
// ecal_pkg: shared types, constants and calendar tables for the epoch to calendar block
`timescale 1ns / 1ps
`default_nettype none
package ecal_pkg;

   // widths
   localparam int TS_W       = 32;   // input seconds count
   localparam int LOC_W      = 34;   // signed local seconds, offset and shift applied
   localparam int ACC_W      = 33;   // working remainder of the shared subtract unit
   localparam int Q_W        = 17;   // quotient shift register
   localparam int K_W        = 5;    // shift step counter
   localparam int DAYS_W     = 17;   // day count before the year walk
   localparam int YP_W       = 13;   // year plus bias, always non-negative
   localparam int SUM_W      = 14;   // weekday sum
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int RSP_DATA_W = 56;   // 50 result bits padded to whole bytes

   // arithmetic constants
   localparam int DAY_SECS   = 86400;
   localparam int HOUR_SECS  = 3600;
   localparam int MIN_SECS   = 60;
   localparam int YEAR_BIAS  = 400;  // 400 years hold a whole number of weeks
   localparam int CENTURY    = 100;
   localparam int WEEK_DAYS  = 7;
   localparam int YEAR_DAYS  = 365;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_YEAR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UTC_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_ENABLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_SHIFT  = 2'd3;

   // configuration seen by the core
   typedef struct packed {
      logic [11:0] epoch_year;
      logic [4:0]  utc_offset_hours;   // two's complement
      logic        dst_enable;
      logic [1:0]  dst_shift_hours;    // two's complement
   } ecal_cfg_type;

   // top to core handshake
   typedef struct packed {
      logic start;       // input transfer this cycle
      logic res_taken;   // result moved into the output register
   } ecal_ctl_type;

   // core to top status
   typedef struct packed {
      logic idle;
      logic res_valid;
   } ecal_sts_type;

   // result item, first field in the highest bits
   typedef struct packed {
      logic       before_epoch;
      logic [1:0] summer_shift;
      logic [5:0] week_of_year;
      logic [2:0] weekday;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day_of_month;
      logic [3:0] month;
      logic [11:0] year;
   } ecal_res_type;

   // days in month, February follows the leap flag
   function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
      logic [4:0] len;
      begin
         unique case (mo)
            4'd2: begin
               len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
               len = 5'd30;
            end
            default: begin
               len = 5'd31;
            end
         endcase
         return len;
      end
   endfunction

   // (31 * shifted month) / 12 term of the weekday congruence
   function automatic logic [4:0] month_term(input logic [3:0] mo);
      logic [4:0] t;
      begin
         unique case (mo)
            4'd1:  t = 5'd28;
            4'd2:  t = 5'd31;
            4'd3:  t = 5'd2;
            4'd4:  t = 5'd5;
            4'd5:  t = 5'd7;
            4'd6:  t = 5'd10;
            4'd7:  t = 5'd12;
            4'd8:  t = 5'd15;
            4'd9:  t = 5'd18;
            4'd10: t = 5'd20;
            4'd11: t = 5'd23;
            default: t = 5'd25;
         endcase
         return t;
      end
   endfunction

endpackage
`default_nettype wire

// File: design/ecal_alu.sv
// ecal_alu: shared compare and subtract unit used by the divide and walk steps of the sequencer
`timescale 1ns / 1ps
`default_nettype none
module ecal_alu
   import ecal_pkg::*;
(
   input  wire logic [ACC_W-1:0] op_a,
   input  wire logic [ACC_W-1:0] op_b,
   output logic                  ge,
   output logic [ACC_W-1:0]      diff
);

   // one subtractor, borrow out gives the compare
   logic [ACC_W:0] wide_diff;

   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge        = ~wide_diff[ACC_W];
   assign diff      = wide_diff[ACC_W-1:0];

endmodule
`default_nettype wire

// File: design/ecal_core.sv
// ecal_core: sequencer and working registers around the shared subtract unit
`timescale 1ns / 1ps
`default_nettype none
module ecal_core
   import ecal_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ecal_cfg_type    cfg,
   input  wire ecal_ctl_type    ctl,
   input  wire logic [TS_W-1:0] timestamp,
   output ecal_sts_type         sts,
   output ecal_res_type         res
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_DDAY  = 4'd2;
   localparam logic [3:0] S_DHR   = 4'd3;
   localparam logic [3:0] S_DMIN  = 4'd4;
   localparam logic [3:0] S_R400  = 4'd5;
   localparam logic [3:0] S_R100  = 4'd6;
   localparam logic [3:0] S_NEGD  = 4'd7;
   localparam logic [3:0] S_YEAR  = 4'd8;
   localparam logic [3:0] S_WEEK  = 4'd9;
   localparam logic [3:0] S_MONTH = 4'd10;
   localparam logic [3:0] S_WDIV  = 4'd11;
   localparam logic [3:0] S_WSUM  = 4'd12;
   localparam logic [3:0] S_WMOD  = 4'd13;
   localparam logic [3:0] S_CHECK = 4'd14;
   localparam logic [3:0] S_DONE  = 4'd15;

   localparam logic signed [LOC_W-1:0] DAY_SECS_L  = LOC_W'(DAY_SECS);
   localparam logic signed [LOC_W-1:0] HOUR_SECS_L = LOC_W'(HOUR_SECS);

   logic [3:0]              state_ff, state_in;
   logic signed [LOC_W-1:0] local_ff, local_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [DAYS_W-1:0]       days_ff, days_in;
   logic [YP_W-1:0]         yp_ff, yp_in;
   logic [8:0]              r400_ff, r400_in;
   logic [6:0]              r100_ff, r100_in;
   logic [3:0]              mo_ff, mo_in;
   logic [4:0]              dom_ff, dom_in;
   logic [4:0]              hour_ff, hour_in;
   logic [5:0]              minute_ff, minute_in;
   logic [5:0]              second_ff, second_in;
   logic [5:0]              week_ff, week_in;
   logic [2:0]              wday_ff, wday_in;
   logic [YP_W-1:0]         wa_ff, wa_in;
   logic                    neg_ff, neg_in;
   logic                    pass2_ff, pass2_in;
   logic [1:0]              shift_ff, shift_in;

   logic [ACC_W-1:0]        alu_a, alu_b, alu_diff, div_base, alu_rem;
   logic                    alu_ge;
   logic [Q_W-1:0]          q_next;
   logic                    div_last;
   logic                    leap;
   logic                    summer;
   logic signed [LOC_W-1:0] ts_ext, off_ext, off_secs, shift_ext, local_fix;
   logic [YP_W-1:0]         year_full;
   logic [SUM_W-1:0]        wsum;

   // shared compare and subtract
   ecal_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .ge   (alu_ge),
      .diff (alu_diff)
   );

   // leap rule from running residues of the biased year
   assign leap = ((yp_ff[1:0] == 2'd0) && (r100_ff != 7'd0)) || (r400_ff == 9'd0);

   // summer window on local time before the shift
   assign summer = ((mo_ff > 4'd3) && (mo_ff < 4'd10))
                || ((mo_ff == 4'd3) && ((dom_ff > 5'd25) || ((dom_ff == 5'd25) && (hour_ff >= 5'd2))))
                || ((mo_ff == 4'd10) && ((dom_ff < 5'd23) || ((dom_ff == 5'd23) && (hour_ff < 5'd3))));

   // zero extension of the timestamp, sign extension of config
   assign ts_ext    = {{(LOC_W-TS_W){1'b0}}, timestamp};
   assign off_ext   = {{(LOC_W-5){cfg.utc_offset_hours[4]}}, cfg.utc_offset_hours};
   assign off_secs  = off_ext * HOUR_SECS_L;
   assign shift_ext = {{(LOC_W-2){cfg.dst_shift_hours[1]}}, cfg.dst_shift_hours};
   assign local_fix = local_ff[LOC_W-1] ? (local_ff + DAY_SECS_L) : local_ff;

   // weekday congruence, all terms non-negative
   assign wsum = SUM_W'(dom_ff) + SUM_W'(wa_ff) + SUM_W'(wa_ff[YP_W-1:2])
               - SUM_W'(q_ff[5:0]) + SUM_W'(q_ff[5:2]) + SUM_W'(month_term(mo_ff));

   // operand selection for the shared unit
   always_comb begin
      div_base = '0;
      unique case (state_ff)
         S_DDAY:         div_base = ACC_W'(DAY_SECS);
         S_DHR:          div_base = ACC_W'(HOUR_SECS);
         S_DMIN:         div_base = ACC_W'(MIN_SECS);
         S_R400:         div_base = ACC_W'(YEAR_BIAS);
         S_R100, S_WDIV: div_base = ACC_W'(CENTURY);
         S_WEEK, S_WMOD: div_base = ACC_W'(WEEK_DAYS);
         default:        div_base = '0;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_YEAR: begin
            alu_a = ACC_W'(days_ff);
            alu_b = ACC_W'(YEAR_DAYS) + ACC_W'(leap);
         end
         S_MONTH: begin
            alu_a = ACC_W'(days_ff);
            alu_b = ACC_W'(month_days(mo_ff, leap));
         end
         default: begin
            alu_a = acc_ff;
            alu_b = div_base << k_ff;
         end
      endcase
   end

   assign alu_rem  = alu_ge ? alu_diff : acc_ff;
   assign q_next   = {q_ff[Q_W-2:0], alu_ge};
   assign div_last = (k_ff == '0);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      local_in  = local_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      k_in      = k_ff;
      days_in   = days_ff;
      yp_in     = yp_ff;
      r400_in   = r400_ff;
      r100_in   = r100_ff;
      mo_in     = mo_ff;
      dom_in    = dom_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      week_in   = week_ff;
      wday_in   = wday_ff;
      wa_in     = wa_ff;
      neg_in    = neg_ff;
      pass2_in  = pass2_ff;
      shift_in  = shift_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               local_in = ts_ext + off_secs;
               pass2_in = 1'b0;
               shift_in = 2'd0;
               state_in = S_LOAD;
            end
         end
         // load the seconds divide, folding a negative local time into the last day of the year before
         S_LOAD: begin
            neg_in   = local_ff[LOC_W-1];
            acc_in   = local_fix[ACC_W-1:0];
            yp_in    = YP_W'(cfg.epoch_year) + YP_W'(YEAR_BIAS) - YP_W'(local_ff[LOC_W-1]);
            q_in     = '0;
            k_in     = K_W'(16);
            state_in = S_DDAY;
         end
         // seconds to days
         S_DDAY: begin
            acc_in = alu_rem;
            q_in   = q_next;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               days_in  = q_next;
               q_in     = '0;
               k_in     = K_W'(4);
               state_in = S_DHR;
            end
         end
         // seconds of day to hours
         S_DHR: begin
            acc_in = alu_rem;
            q_in   = q_next;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               hour_in  = q_next[4:0];
               q_in     = '0;
               k_in     = K_W'(5);
               state_in = S_DMIN;
            end
         end
         // seconds of hour to minutes and seconds
         S_DMIN: begin
            acc_in = alu_rem;
            q_in   = q_next;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               minute_in = q_next[5:0];
               second_in = alu_rem[5:0];
               acc_in    = ACC_W'(yp_ff);
               q_in      = '0;
               k_in      = K_W'(3);
               state_in  = S_R400;
            end
         end
         // starting year residue modulo 400
         S_R400: begin
            acc_in = alu_rem;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               r400_in  = alu_rem[8:0];
               k_in     = K_W'(1);
               state_in = S_R100;
            end
         end
         // and modulo 100
         S_R100: begin
            acc_in = alu_rem;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               r100_in  = alu_rem[6:0];
               state_in = neg_ff ? S_NEGD : S_YEAR;
            end
         end
         S_NEGD: begin
            days_in  = DAYS_W'(YEAR_DAYS - 1) + DAYS_W'(leap);
            state_in = S_YEAR;
         end
         // year walk
         S_YEAR: begin
            if (alu_ge) begin
               days_in = alu_diff[DAYS_W-1:0];
               yp_in   = yp_ff + 1'b1;
               r100_in = (r100_ff == 7'(CENTURY - 1)) ? 7'd0 : r100_ff + 1'b1;
               r400_in = (r400_ff == 9'(YEAR_BIAS - 1)) ? 9'd0 : r400_ff + 1'b1;
            end else begin
               acc_in   = ACC_W'(days_ff);
               q_in     = '0;
               k_in     = K_W'(5);
               state_in = S_WEEK;
            end
         end
         // week of year
         S_WEEK: begin
            acc_in = alu_rem;
            q_in   = q_next;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               week_in  = q_next[5:0] + 1'b1;
               mo_in    = 4'd1;
               state_in = S_MONTH;
            end
         end
         // month walk
         S_MONTH: begin
            if (alu_ge && (mo_ff != 4'd12)) begin
               days_in = alu_diff[DAYS_W-1:0];
               mo_in   = mo_ff + 1'b1;
            end else begin
               dom_in   = days_ff[4:0] + 1'b1;
               wa_in    = yp_ff - YP_W'(mo_ff <= 4'd2);
               acc_in   = ACC_W'(yp_ff - YP_W'(mo_ff <= 4'd2));
               q_in     = '0;
               k_in     = K_W'(5);
               state_in = S_WDIV;
            end
         end
         // centuries of the shifted year
         S_WDIV: begin
            acc_in = alu_rem;
            q_in   = q_next;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               state_in = S_WSUM;
            end
         end
         S_WSUM: begin
            acc_in   = ACC_W'(wsum);
            k_in     = K_W'(10);
            state_in = S_WMOD;
         end
         // weekday sum modulo 7
         S_WMOD: begin
            acc_in = alu_rem;
            k_in   = k_ff - 1'b1;
            if (div_last) begin
               wday_in  = alu_rem[2:0];
               state_in = S_CHECK;
            end
         end
         // summer time redoes the whole pass on the shifted time
         S_CHECK: begin
            if (!pass2_ff && cfg.dst_enable && !neg_ff && summer
                && (cfg.dst_shift_hours != 2'd0)) begin
               pass2_in = 1'b1;
               shift_in = cfg.dst_shift_hours;
               local_in = local_ff + shift_ext * HOUR_SECS_L;
               state_in = S_LOAD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (ctl.res_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      local_ff  <= local_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      k_ff      <= k_in;
      days_ff   <= days_in;
      yp_ff     <= yp_in;
      r400_ff   <= r400_in;
      r100_ff   <= r100_in;
      mo_ff     <= mo_in;
      dom_ff    <= dom_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      week_ff   <= week_in;
      wday_ff   <= wday_in;
      wa_ff     <= wa_in;
      neg_ff    <= neg_in;
      shift_ff  <= shift_in;
   end

   // result and status
   assign year_full = yp_ff - YP_W'(YEAR_BIAS);

   assign sts.idle      = (state_ff == S_IDLE);
   assign sts.res_valid = (state_ff == S_DONE);

   assign res.year         = year_full[11:0];
   assign res.month        = mo_ff;
   assign res.day_of_month = dom_ff;
   assign res.hour         = hour_ff;
   assign res.minute       = minute_ff;
   assign res.second       = second_ff;
   assign res.weekday      = wday_ff;
   assign res.week_of_year = week_ff;
   assign res.summer_shift = shift_ff;
   assign res.before_epoch = neg_ff;

endmodule
`default_nettype wire

// File: design/epoch_seconds_to_calendar_top.sv
// epoch_seconds_to_calendar_top: config registers, input transfer and output register
//
//   channel  direction  handshake                payload
//   req_     in         req_tvalid / req_tready  req_tdata: timestamp
//   rsp_     out        rsp_tvalid / rsp_tready  rsp_tdata: calendar fields
//   csr_     in         csr_valid / csr_ready    csr_index, csr_data
//
// the time per item grows with the years and months walked on the shared subtract
// unit, and a local time before the epoch adds the S_NEGD state; a timestamp in the
// summer window takes a second pass. req_tready is high only while the sequencer
// is idle; a finished result waits in the output register without blocking the
// next transfer in. reset is synchronous and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module epoch_seconds_to_calendar_top
   import ecal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TS_W-1:0]       req_tdata,    // [31:0] timestamp
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,    // [11:0] year, [15:12] month,
                                                    // [20:16] day_of_month, [25:21] hour,
                                                    // [31:26] minute, [37:32] second,
                                                    // [40:38] weekday, [46:41] week_of_year,
                                                    // [48:47] summer_shift, [49] before_epoch
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ecal_cfg_type cfg_ff, cfg_in;
   ecal_ctl_type ctl;
   ecal_sts_type sts;
   ecal_res_type core_res;
   ecal_res_type rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         load_rsp;

   // register writes always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_EPOCH_YEAR: cfg_in.epoch_year       = csr_data[11:0];
            CSR_UTC_OFFSET: cfg_in.utc_offset_hours = csr_data[4:0];
            CSR_DST_ENABLE: cfg_in.dst_enable       = csr_data[0];
            CSR_DST_SHIFT:  cfg_in.dst_shift_hours  = csr_data[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.epoch_year       <= 12'd1970;
         cfg_ff.utc_offset_hours <= 5'd0;
         cfg_ff.dst_enable       <= 1'b0;
         cfg_ff.dst_shift_hours  <= 2'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input transfer starts the sequencer
   assign req_tready    = sts.idle;
   assign ctl.start     = req_tvalid & req_tready;
   assign load_rsp      = sts.res_valid & (~rsp_valid_ff | rsp_tready);
   assign ctl.res_taken = load_rsp;

   ecal_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ctl       (ctl),
      .timestamp (req_tdata),
      .sts       (sts),
      .res       (core_res)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(ecal_res_type)){1'b0}}, rsp_data_ff};

endmodule
`default_nettype wire

// File: bench/epoch_seconds_to_calendar_top_tb.sv
// epoch_seconds_to_calendar_top_tb: self-checking bench for the epoch seconds to calendar block
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_top_tb;
   import ecal_pkg::*;

   // one directed row: zone settings, timestamp, optional hand-typed calendar
   typedef struct packed {
      ecal_cfg_type zone;
      logic [31:0]  stamp;
      logic         pinned;
      ecal_res_type calendar;
   } stamp_case_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TS_W-1:0]       req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // hand-typed expectation travels beside the timestamp
   logic                  pin_valid = 1'b0;
   ecal_res_type          pin_calendar = '0;

   ecal_res_type          calendar_due[$];
   ecal_cfg_type          zone_now;
   stamp_case_type        stamp_cases[$];
   int                    mismatch_count = 0;
   bit                    calm = 1'b0;
   bit                    squeeze = 1'b0;

   epoch_seconds_to_calendar_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #150_000_000;
      $display("epoch_seconds_to_calendar_top: mismatch");
      $finish;
   end

   // gregorian leap rule
   function automatic longint leap_of(input longint y);
      return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 1 : 0;
   endfunction

   function automatic longint month_span(input longint mo, input longint y);
      longint len;
      case (mo)
         2: len = 28 + leap_of(y);
         4, 6, 9, 11: len = 30;
         default: len = 31;
      endcase
      return len;
   endfunction

   // local seconds since epoch start to calendar fields, no summer time
   function automatic ecal_res_type civil_from_local(input longint secs, input longint ep);
      ecal_res_type r;
      longint days, rem, y, mo, k, a, mm, dom;
      r = '0;
      y = ep;
      mo = 1;
      if (secs < 0) begin
         r.before_epoch = 1'b1;
         secs += 86400;
         y -= 1;
         days = 364 + leap_of(y);
      end else begin
         days = secs / 86400;
      end
      rem = secs % 86400;
      r.hour = rem / 3600;
      r.minute = (rem % 3600) / 60;
      r.second = rem % 60;
      while (days >= 365 + leap_of(y)) begin
         days -= 365 + leap_of(y);
         y++;
      end
      r.week_of_year = days / 7 + 1;
      while (mo < 12 && days >= month_span(mo, y)) begin
         days -= month_span(mo, y);
         mo++;
      end
      dom = days + 1;
      r.year = y;
      r.month = mo;
      r.day_of_month = dom;
      // shifted-year congruence, 400 years bias keeps every term positive
      k = (14 - mo) / 12;
      a = y + 400 - k;
      mm = mo + 12 * k - 2;
      r.weekday = (dom + a + a / 4 - a / 100 + a / 400 + (31 * mm) / 12) % 7;
      return r;
   endfunction

   // full conversion of one timestamp under the given zone settings
   function automatic ecal_res_type calendar_of(input logic [31:0] stamp,
                                                input ecal_cfg_type z);
      ecal_res_type r;
      longint base, shift;
      bit summer;
      base = longint'(stamp) + longint'($signed(z.utc_offset_hours)) * 3600;
      r = civil_from_local(base, longint'(z.epoch_year));
      summer = (r.month > 3 && r.month < 10)
            || (r.month == 3 && (r.day_of_month > 25 || (r.day_of_month == 25 && r.hour >= 2)))
            || (r.month == 10 && (r.day_of_month < 23 || (r.day_of_month == 23 && r.hour < 3)));
      if (z.dst_enable && !r.before_epoch && summer) begin
         shift = longint'($signed(z.dst_shift_hours));
         r = civil_from_local(base + shift * 3600, longint'(z.epoch_year));
         r.summer_shift = z.dst_shift_hours;
      end
      return r;
   endfunction

   function automatic ecal_cfg_type mk_zone(input int ep, input int off, input int en,
                                            input int sh);
      ecal_cfg_type z;
      z.epoch_year = ep[11:0];
      z.utc_offset_hours = off[4:0];
      z.dst_enable = en[0];
      z.dst_shift_hours = sh[1:0];
      return z;
   endfunction

   function automatic ecal_res_type mk_cal(input int y, input int mo, input int dm, input int h,
                                           input int mi, input int s, input int wd,
                                           input int wk, input int sh, input int pre);
      ecal_res_type r;
      r.year = y[11:0];
      r.month = mo[3:0];
      r.day_of_month = dm[4:0];
      r.hour = h[4:0];
      r.minute = mi[5:0];
      r.second = s[5:0];
      r.weekday = wd[2:0];
      r.week_of_year = wk[5:0];
      r.summer_shift = sh[1:0];
      r.before_epoch = pre[0];
      return r;
   endfunction

   function automatic string calendar_text(input ecal_res_type c);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd %0d wk %0d shift %0d pre %0d",
                       c.year, c.month, c.day_of_month, c.hour, c.minute, c.second,
                       c.weekday, c.week_of_year, $signed(c.summer_shift), c.before_epoch);
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 25);
      return $urandom_range(60, 200);
   endfunction

   // local days from epoch start to a date
   function automatic longint days_to(input longint yr, input longint mo, input longint dm,
                                      input longint ep);
      longint d, y, m;
      d = 0;
      for (y = ep; y < yr; y++) d += 365 + leap_of(y);
      for (m = 1; m < mo; m++) d += month_span(m, yr);
      return d + dm - 1;
   endfunction

   // random timestamp, biased toward range ends and calendar edges
   function automatic logic [31:0] pick_stamp(input ecal_cfg_type z);
      int unsigned sel;
      longint ep, off, yr, mo, dm, hr, ts;
      sel = $urandom_range(0, 99);
      ep = z.epoch_year;
      off = longint'($signed(z.utc_offset_hours));
      if (sel < 35) return $urandom;
      if (sel < 45) return $urandom_range(0, 200000);
      if (sel < 50) return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      yr = ep + $urandom_range(0, 135);
      case ($urandom_range(0, 5))
         0: begin
            mo = 3; dm = 25; hr = 2;
         end
         1: begin
            mo = 10; dm = 23; hr = 3;
         end
         2: begin
            mo = 1; dm = 1; hr = 0;
         end
         3: begin
            mo = 3; dm = 1; hr = 0;
         end
         4: begin
            mo = 12; dm = 31; hr = 23;
         end
         default: begin
            mo = $urandom_range(1, 12);
            dm = $urandom_range(1, 28);
            hr = $urandom_range(0, 23);
         end
      endcase
      ts = days_to(yr, mo, dm, ep) * 86400 + hr * 3600 - off * 3600;
      case ($urandom_range(0, 3))
         0: ts = ts;
         1: ts = ts - 1;
         2: ts = ts + $urandom_range(0, 7200);
         default: ts = ts - $urandom_range(0, 7200);
      endcase
      if (ts < 0 || ts > longint'(32'hFFFF_FFFF)) return $urandom;
      return ts[31:0];
   endfunction

   // follow register writes, predict on every input transfer, check every result transfer
   always @(posedge clock) begin : scoreboard
      ecal_res_type got, want;
      if (reset) begin
         zone_now = mk_zone(1970, 0, 0, 1);
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EPOCH_YEAR: zone_now.epoch_year = csr_data;
               CSR_UTC_OFFSET: zone_now.utc_offset_hours = csr_data[4:0];
               CSR_DST_ENABLE: zone_now.dst_enable = csr_data[0];
               default: zone_now.dst_shift_hours = csr_data[1:0];
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (pin_valid) calendar_due.push_back(pin_calendar);
            else calendar_due.push_back(calendar_of(req_tdata, zone_now));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(ecal_res_type)-1:0];
            if (calendar_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: %s", calendar_text(got));
            end else begin
               want = calendar_due.pop_front();
               if (got.year !== want.year || got.month !== want.month
                   || got.day_of_month !== want.day_of_month || got.hour !== want.hour
                   || got.minute !== want.minute || got.second !== want.second
                   || got.weekday !== want.weekday || got.week_of_year !== want.week_of_year
                   || got.summer_shift !== want.summer_shift
                   || got.before_epoch !== want.before_epoch) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("calendar differs: expected %s, got %s",
                              calendar_text(want), calendar_text(got));
               end
            end
         end
      end
   end

   // result side: ready runs, random stalls, one long hold-off
   initial begin : result_sink
      @(negedge reset);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
         end else if (calm || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_len() + 1) @(posedge clock);
         end
      end
   end

   // one timestamp transfer after a random gap
   task automatic offer(input logic [31:0] stamp, input logic pinned, input ecal_res_type cal);
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= stamp;
      pin_valid <= pinned;
      pin_calendar <= cal;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait for every outstanding calendar
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (calendar_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register transfer, valid stays up for the next one
   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // write all four registers, unused upper data bits carry junk
   task automatic load_zone(input ecal_cfg_type z);
      logic [31:0] junk;
      junk = $urandom;
      put_reg(CSR_EPOCH_YEAR, z.epoch_year);
      put_reg(CSR_UTC_OFFSET, {junk[6:0], z.utc_offset_hours});
      put_reg(CSR_DST_ENABLE, {junk[17:7], z.dst_enable});
      put_reg(CSR_DST_SHIFT, {junk[27:18], z.dst_shift_hours});
      csr_valid <= 1'b0;
   endtask

   task automatic add_case(input ecal_cfg_type z, input logic [31:0] stamp,
                           input logic pinned, input ecal_res_type cal);
      stamp_case_type c;
      c.zone = z;
      c.stamp = stamp;
      c.pinned = pinned;
      c.calendar = cal;
      stamp_cases.push_back(c);
   endtask

   initial begin : stimulus
      ecal_cfg_type cur, z;
      ecal_cfg_type plain, behind, summer_n, summer_s, far_west, out_hi, out_lo, wrap;
      int sent;

      plain    = mk_zone(1970, 0, 0, 1);
      behind   = mk_zone(1970, -1, 1, 1);
      summer_n = mk_zone(1970, 0, 1, 1);
      summer_s = mk_zone(1970, 0, 1, -1);
      far_west = mk_zone(1900, -12, 0, 1);
      out_hi   = mk_zone(2100, 14, 1, -2);
      out_lo   = mk_zone(0, -16, 1, 0);
      wrap     = mk_zone(4095, 15, 1, 1);

      // register defaults straight after reset
      add_case(plain, 32'd0, 1'b1, mk_cal(1970, 1, 1, 0, 0, 0, 4, 1, 0, 0));
      add_case(plain, 32'hFFFF_FFFF, 1'b1, mk_cal(2106, 2, 7, 6, 28, 15, 0, 6, 0, 0));
      add_case(plain, 32'd86399, 1'b1, mk_cal(1970, 1, 1, 23, 59, 59, 4, 1, 0, 0));
      add_case(plain, 32'd951782400, 1'b0, '0);    // leap day 2000
      add_case(plain, 32'd946684799, 1'b0, '0);    // last second of 1999
      add_case(plain, 32'd4107542400, 1'b0, '0);   // century year without leap day
      // negative offset pulls local time before the epoch start
      add_case(behind, 32'd0, 1'b1, mk_cal(1969, 12, 31, 23, 0, 0, 3, 53, 0, 1));
      add_case(behind, 32'd3599, 1'b0, '0);
      add_case(behind, 32'd3600, 1'b0, '0);
      // summer window edges and a date carried by the shift
      add_case(summer_n, 32'd1616637599, 1'b0, '0);
      add_case(summer_n, 32'd1616637600, 1'b0, '0);
      add_case(summer_n, 32'd1634957999, 1'b0, '0);
      add_case(summer_n, 32'd1634958000, 1'b0, '0);
      add_case(summer_n, 32'd1627774200, 1'b0, '0);
      // southern shift moves back across midnight
      add_case(summer_s, 32'd1625099400, 1'b0, '0);
      // range extremes of epoch and offset
      add_case(far_west, 32'd0, 1'b1, mk_cal(1899, 12, 31, 12, 0, 0, 0, 53, 0, 1));
      add_case(far_west, 32'hFFFF_FFFF, 1'b0, '0);
      // register values outside the stated ranges
      add_case(out_hi, 32'd0, 1'b0, '0);
      add_case(out_hi, 32'd15000000, 1'b0, '0);
      add_case(out_lo, 32'd0, 1'b0, '0);
      add_case(out_lo, 32'd20000000, 1'b0, '0);
      // year past 12 bits
      add_case(wrap, 32'd0, 1'b0, '0);
      add_case(wrap, 32'hFFFF_FFFF, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      cur = plain;
      foreach (stamp_cases[i]) begin
         if (stamp_cases[i].zone != cur) begin
            settle();
            cur = stamp_cases[i].zone;
            load_zone(cur);
         end
         offer(stamp_cases[i].stamp, stamp_cases[i].pinned, stamp_cases[i].calendar);
      end

      // random phases, each under its own zone settings
      sent = 0;
      for (int ph = 0; ph < 11; ph++) begin
         settle();
         case (ph)
            0: z = summer_n;
            1: z = mk_zone(1900, -12, 1, -1);
            2: z = mk_zone(2100, 14, 1, 1);
            3: z = mk_zone(0, -16, 1, -2);
            4: z = mk_zone(4095, 15, 1, 0);
            5: z = mk_zone(2000, 5, 0, 1);
            default: z = mk_zone($urandom_range(1900, 2100), int'($urandom_range(0, 26)) - 12,
                                 $urandom_range(0, 1), int'($urandom_range(0, 2)) - 1);
         endcase
         load_zone(z);
         for (int k = 0; k < 150; k++) begin
            calm = (k < 30);
            if (sent == 200) squeeze = 1'b1;
            offer(pick_stamp(z), 1'b0, '0);
            sent++;
         end
         calm = 1'b0;
      end

      settle();
      repeat (500) @(posedge clock);
      if (mismatch_count == 0 && calendar_due.size() == 0) begin
         $display("epoch_seconds_to_calendar_top: match");
      end else begin
         $display("epoch_seconds_to_calendar_top: mismatch");
      end
      $finish;
   end

endmodule
